FILE: rtl/uart_receiver_with_timeout_top_defines.svh
// assertion macros for the uart receiver top level rtl
`ifndef UART_RECEIVER_WITH_TIMEOUT_TOP_DEFINES_SVH
`define UART_RECEIVER_WITH_TIMEOUT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, quiet while reset is held
`define URX_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define URX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define URX_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define URX_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/uart_rxto_pkg.sv
// shared types and constants of the uart receiver with timeout
package uart_rxto_pkg;

    localparam int unsigned MODE_W    = 1;
    localparam int unsigned TICK_W    = 13;
    localparam int unsigned TOUT_W    = 20;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 20;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BITS_W    = 4;

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

    // line modes
    localparam logic [MODE_W-1:0] MODE_SINGLE = 1'b0;
    localparam logic [MODE_W-1:0] MODE_DIFF   = 1'b1;

    // reset values of the registers
    localparam logic [MODE_W-1:0] RST_LINE_MODE     = MODE_SINGLE;
    localparam logic [TICK_W-1:0] RST_BIT_TICKS     = 13'd16;
    localparam logic [TOUT_W-1:0] RST_TIMEOUT_TICKS = 20'd131072;

    // legal bit period range
    localparam logic [TICK_W-1:0] PERIOD_MIN = 13'd2;
    localparam logic [TICK_W-1:0] PERIOD_MAX = 13'd4096;

    typedef struct packed {
        logic [MODE_W-1:0] line_mode;
        logic [TICK_W-1:0] period;
        logic [TOUT_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic              byte_ready;
        logic              timed_out;
        logic [BYTE_W-1:0] data_byte;
        logic              busy_res;
    } t_res;

endpackage

FILE: rtl/uart_rxto_cfg.sv
// configuration registers and bit period clamp
module uart_rxto_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [uart_rxto_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [uart_rxto_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output uart_rxto_pkg::t_cfg                 o_cfg
);

    logic [uart_rxto_pkg::MODE_W-1:0] r_line_mode;
    logic [uart_rxto_pkg::TICK_W-1:0] r_bit_ticks;
    logic [uart_rxto_pkg::TOUT_W-1:0] r_timeout_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode     <= uart_rxto_pkg::RST_LINE_MODE;
            r_bit_ticks     <= uart_rxto_pkg::RST_BIT_TICKS;
            r_timeout_ticks <= uart_rxto_pkg::RST_TIMEOUT_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                uart_rxto_pkg::CFG_LINE_MODE: begin
                    r_line_mode <= i_cfg_data[uart_rxto_pkg::MODE_W-1:0];
                end
                uart_rxto_pkg::CFG_BIT_TICKS: begin
                    r_bit_ticks <= i_cfg_data[uart_rxto_pkg::TICK_W-1:0];
                end
                uart_rxto_pkg::CFG_TIMEOUT_TICKS: begin
                    r_timeout_ticks <= i_cfg_data[uart_rxto_pkg::TOUT_W-1:0];
                end
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.line_mode     = r_line_mode;
        o_cfg.timeout_ticks = r_timeout_ticks;
        if (r_bit_ticks < uart_rxto_pkg::PERIOD_MIN) begin
            o_cfg.period = uart_rxto_pkg::PERIOD_MIN;
        end else if (r_bit_ticks > uart_rxto_pkg::PERIOD_MAX) begin
            o_cfg.period = uart_rxto_pkg::PERIOD_MAX;
        end else begin
            o_cfg.period = r_bit_ticks;
        end
    end

endmodule

FILE: rtl/uart_rxto_core.sv
// receive state machine, one sample tick per step
module uart_rxto_core #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_arm,
    input  logic                i_line_a,
    input  logic                i_line_b,
    input  uart_rxto_pkg::t_cfg i_cfg,
    output uart_rxto_pkg::t_res o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HUNT,
        PH_RECV,
        PH_STOP
    } t_phase;

    t_phase                           r_phase;
    logic [uart_rxto_pkg::TICK_W-1:0] r_tick_count;
    logic [uart_rxto_pkg::BITS_W-1:0] r_bits_taken;
    logic [DATA_BITS-1:0]             r_shift_byte;
    logic [uart_rxto_pkg::TOUT_W-1:0] r_timeout_count;

    t_phase                           n_phase;
    logic [uart_rxto_pkg::TICK_W-1:0] n_tick_count;
    logic [uart_rxto_pkg::BITS_W-1:0] n_bits_taken;
    logic [DATA_BITS-1:0]             n_shift_byte;
    logic [uart_rxto_pkg::TOUT_W-1:0] n_timeout_count;

    logic start_lvl;
    logic data_bit;

    // decode line levels for the active mode
    always_comb begin
        if (i_cfg.line_mode == uart_rxto_pkg::MODE_DIFF) begin
            start_lvl = i_line_b && !i_line_a;
            data_bit  = i_line_a && !i_line_b;
        end else begin
            start_lvl = i_line_a;
            data_bit  = !i_line_a;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_tick_count    = r_tick_count;
        n_bits_taken    = r_bits_taken;
        n_shift_byte    = r_shift_byte;
        n_timeout_count = r_timeout_count;
        o_res           = '0;

        if (i_arm) begin
            n_phase         = PH_HUNT;
            n_timeout_count = '0;
            n_tick_count    = '0;
            n_bits_taken    = '0;
        end

        unique case (n_phase)
            PH_HUNT: begin
                if (start_lvl) begin
                    n_phase      = PH_RECV;
                    n_tick_count = i_cfg.period + (i_cfg.period >> 1);
                    n_bits_taken = '0;
                    n_shift_byte = '0;
                end else begin
                    n_timeout_count = n_timeout_count + 1'b1;
                    if (n_timeout_count >= i_cfg.timeout_ticks) begin
                        o_res.timed_out = 1'b1;
                        n_phase         = PH_IDLE;
                    end
                end
            end
            PH_RECV: begin
                if (n_tick_count != '0) begin
                    n_tick_count = n_tick_count - 1'b1;
                end
                if (n_tick_count == '0) begin
                    // lsb first: new bit enters at the top
                    n_shift_byte = {data_bit, n_shift_byte[DATA_BITS-1:1]};
                    n_bits_taken = n_bits_taken + 1'b1;
                    n_tick_count = i_cfg.period;
                    if (n_bits_taken >= uart_rxto_pkg::BITS_W'(DATA_BITS)) begin
                        n_phase = PH_STOP;
                    end
                end
            end
            default: begin
            end
        endcase

        // stop check also runs on the tick of the last sample
        if (n_phase == PH_STOP && !start_lvl) begin
            o_res.byte_ready = 1'b1;
            o_res.data_byte  = uart_rxto_pkg::BYTE_W'(n_shift_byte);
            n_phase          = PH_IDLE;
        end

        o_res.busy_res = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_tick_count    <= '0;
            r_bits_taken    <= '0;
            r_shift_byte    <= '0;
            r_timeout_count <= '0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_tick_count    <= n_tick_count;
            r_bits_taken    <= n_bits_taken;
            r_shift_byte    <= n_shift_byte;
            r_timeout_count <= n_timeout_count;
        end
    end

endmodule

FILE: rtl/uart_receiver_with_timeout_top.sv
// top level of the uart receiver with start-bit timeout
//
// usage:
//   each input beat is one sample tick of the serial line: arm, line_a and
//   line_b. every input beat yields exactly one output beat carrying
//   byte_ready, timed_out, data_byte and busy_res for that tick.
//   both channels use valid/stall; a beat moves when valid is high and
//   stall is low.
// throughput and flow:
//   one beat per clock while the output is not stalled. a beat lands in
//   the input register on its accept edge; the receive state machine and
//   the result register update when the beat steps out of the input
//   register, and the result is offered from the result register.
//   the one-tick state update is the only loop.
// stall behavior:
//   while the output beat waits under stall, the input register still
//   takes one more beat; input stall rises only once both are full.
// reset:
//   synchronous active low. the receiver returns to idle, counters and
//   shift register clear, both stages empty, and the config registers go
//   to single-line mode, 16 ticks per bit and a 131072-tick timeout.
// config:
//   plain write port, index 0 line mode, 1 bit ticks, 2 timeout ticks;
//   write only while the receiver has no beats in flight.
`include "uart_receiver_with_timeout_top_defines.svh"

module uart_receiver_with_timeout_top #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [uart_rxto_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [uart_rxto_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_arm,
    input  logic                                i_line_a,
    input  logic                                i_line_b,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_byte_ready,
    output logic                                o_timed_out,
    output logic [uart_rxto_pkg::BYTE_W-1:0]    o_data_byte,
    output logic                                o_busy_res
);

    uart_rxto_pkg::t_cfg cfg;
    uart_rxto_pkg::t_res res;

    // input stage
    logic r_in_valid;
    logic r_arm;
    logic r_line_a;
    logic r_line_b;

    // result stage
    logic                r_out_valid;
    uart_rxto_pkg::t_res r_res;

    logic out_free;   // result register can take a beat this cycle
    logic step;       // input register advances into the receiver
    logic in_acc;     // input beat accepted

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    uart_rxto_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    uart_rxto_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_arm    (r_arm),
        .i_line_a (r_line_a),
        .i_line_b (r_line_b),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    // valid flags of both stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_arm    <= i_arm;
            r_line_a <= i_line_a;
            r_line_b <= i_line_b;
        end
        if (step) begin
            r_res <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_ready = r_res.byte_ready;
    assign o_timed_out  = r_res.timed_out;
    assign o_data_byte  = r_res.data_byte;
    assign o_busy_res   = r_res.busy_res;

    // a tick cannot both finish a byte and time out
    `URX_ASSERT_RST(a_done_excl, i_clk, i_rst_n, o_out_valid |-> !(o_byte_ready && o_timed_out), "byte_ready and timed_out together")

    // data is zero unless a byte completed
    `URX_ASSERT_RST(a_data_zero, i_clk, i_rst_n, (o_out_valid && !o_byte_ready) |-> (o_data_byte == '0), "data_byte set without byte_ready")

    // finishing a byte or timing out leaves the receiver idle
    `URX_ASSERT_RST(a_end_idle, i_clk, i_rst_n, (o_out_valid && (o_byte_ready || o_timed_out)) |-> !o_busy_res, "busy after end of attempt")

    // input stalls only when a result is held back downstream
    `URX_ASSERT_ALWAYS(a_stall_src, i_clk, o_in_stall |-> (o_out_valid && i_out_stall), "input stall without output stall")

endmodule
